/* src/mfrc_pkg.sv */
// Shared constants and types of the mains frequency relay controller.
// No dependencies; imported by mfrc_div and mains_frequency_relay_controller.
`timescale 1ns / 1ps
`default_nettype none

package mfrc_pkg;

  localparam int unsigned FRAME_LEN  = 3000;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned LEVEL_W    = 26;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned MUL_A_W    = 26;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_W      = 30;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [POS_W-1:0]   LAST_POS       = POS_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0]   SIXTH_IDX      = CNT_W'(5);
  localparam logic [CNT_W-1:0]   LAST_IDX       = CNT_W'(25);
  localparam logic [CNT_W-1:0]   NEEDED         = CNT_W'(26);
  localparam logic [MUL_B_W-1:0] RATE_SCALE     = MUL_B_W'(10000);
  localparam logic [MUL_B_W-1:0] GAIN_ONE       = MUL_B_W'(65536);
  localparam logic [FREQ_W-1:0]  FREQ_MAX       = {FREQ_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FILTER_GAIN = 3'd0,
    CFG_CROSS_LEVEL = 3'd1,
    CFG_SAMPLE_RATE = 3'd2,
    CFG_LOW_LIMIT   = 3'd3,
    CFG_HIGH_LIMIT  = 3'd4,
    CFG_RELAY_MODES = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL0,
    ST_FMUL1,
    ST_FADD,
    ST_CHECK,
    ST_RMUL,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* src/mfrc_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mfrc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module mfrc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [mfrc_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [mfrc_pkg::POS_W-1:0]  divisor_i,
  output logic                           done_o,
  output logic [mfrc_pkg::DIV_W-1:0]       quotient_o
);
  import mfrc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [POS_W-1:0]     rem_q, rem_d;
  logic [POS_W-1:0]     dvs_q, dvs_d;
  logic [POS_W:0]       shifted;
  logic [POS_W+1:0]     diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[POS_W+1]) begin
        rem_d = diff[POS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[POS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* src/mains_frequency_relay_controller.sv */
// Top level of the mains frequency relay controller.
// Depends on mfrc_pkg and mfrc_div.
//
// Usage:
//   Slave stream carries 10-bit voltage samples in frames of FRAME_LEN.
//   Master stream carries one result per frame, after the last sample.
//   Config port writes one register per cycle with cfg_we_i high.
// Sequence:
//   Sample 0 of a frame is taken in the idle state. Other samples pass through
//   states FMUL0, FMUL1 and FADD: one shared 26x17 multiplier used twice plus the
//   filter add and crossing test. Last sample, if enough crossings: the multiplier forms rate*10000, then a
//   30-step restoring divider (one quotient bit per cycle) yields the
//   frequency, then relay rules run and the result loads the output register.
//   s_axis_tready is high only between items.
// Reset: configuration and sequencer registers back to defaults, relays off, frame position 0.
// Stall: the result waits in the output register; the next samples are
//   still taken, and only a following frame end waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module mains_frequency_relay_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] voltage_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [23:0] frequency_mhz, [24] light_relay,
                                           // [25] socket_relay
  output logic             m_axis_tuser,   // [0] frequency_valid
  input  wire logic        cfg_we_i,
  input  wire logic [mfrc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [mfrc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mfrc_pkg::*;

  // configuration
  logic [GAIN_W-1:0]   gain_q;
  logic [SAMPLE_W-1:0] level_q;
  logic [RATE_W-1:0]   rate_q;
  logic [FREQ_W-1:0]   low_q, high_q;
  logic [3:0]          modes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_W'(1996);
      level_q <= SAMPLE_W'(511);
      rate_q  <= RATE_W'(10000);
      low_q   <= FREQ_W'(49975);
      high_q  <= FREQ_W'(50025);
      modes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FILTER_GAIN: gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_CROSS_LEVEL: level_q <= cfg_wdata_i[SAMPLE_W-1:0];
        CFG_SAMPLE_RATE: rate_q  <= cfg_wdata_i[RATE_W-1:0];
        CFG_LOW_LIMIT:   low_q   <= cfg_wdata_i[FREQ_W-1:0];
        CFG_HIGH_LIMIT:  high_q  <= cfg_wdata_i[FREQ_W-1:0];
        CFG_RELAY_MODES: modes_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e              state_q, state_d;
  logic [LEVEL_W-1:0]  flt_q, flt_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [POS_W-1:0]    sixth_q, sixth_d;
  logic [POS_W-1:0]    last_q, last_d;
  logic [1:0]          relay_q, relay_d;
  logic                mvalid_q, mvalid_d;

  // datapath
  logic [SAMPLE_W-1:0] x_q, x_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [LEVEL_W:0]    part_q, part_d;
  logic [FREQ_W-1:0]   res_f_q, res_f_d;
  logic                res_v_q, res_v_d;
  logic [31:0]         mdata_q, mdata_d;
  logic                muser_q, muser_d;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   rnd;
  logic [LEVEL_W+1:0]  sum;
  logic [LEVEL_W-1:0]  nxt;
  logic [LEVEL_W-1:0]  lvl;
  logic                crossed;
  logic                div_start, div_done;
  logic [DIV_W-1:0]    quotient;
  logic [FREQ_W-1:0]   freq;
  logic                la, sa, lm, sm;
  logic                s_acc;

  assign mul_p = mul_a * mul_b;
  assign rnd   = prod_q + PROD_W'(32768);
  assign lvl   = {level_q, 16'h0000};
  assign sum   = {1'b0, part_q} + {2'b00, prod_q[LEVEL_W-1:0]};
  assign nxt   = sum[LEVEL_W-1:0];
  assign crossed = (flt_q < lvl) != (nxt < lvl);
  assign freq  = (quotient[DIV_W-1:FREQ_W] != '0) ? FREQ_MAX : quotient[FREQ_W-1:0];
  assign la = modes_q[0];
  assign sa = modes_q[1];
  assign lm = modes_q[2];
  assign sm = modes_q[3];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  mfrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[DIV_W-1:0]),
    .divisor_i  (last_q - sixth_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d   = state_q;
    flt_d     = flt_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    sixth_d   = sixth_q;
    last_d    = last_q;
    relay_d   = relay_q;
    mvalid_d  = mvalid_q;
    x_d       = x_q;
    prod_d    = prod_q;
    part_d    = part_q;
    res_f_d   = res_f_q;
    res_v_d   = res_v_q;
    mdata_d   = mdata_q;
    muser_d   = muser_q;
    mul_a     = flt_q;
    mul_b     = GAIN_ONE - {1'b0, gain_q};
    div_start = 1'b0;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          x_d = s_axis_tdata[SAMPLE_W-1:0];
          if (pos_q == '0) begin
            flt_d   = '0;
            cnt_d   = '0;
            sixth_d = '0;
            last_d  = '0;
            pos_d   = POS_W'(1);
          end else begin
            state_d = ST_FMUL0;
          end
        end
      end
      ST_FMUL0: begin
        prod_d  = mul_p;
        state_d = ST_FMUL1;
      end
      ST_FMUL1: begin
        mul_a   = MUL_A_W'(x_q);
        mul_b   = MUL_B_W'(gain_q);
        part_d  = rnd[PROD_W-1:16];
        prod_d  = mul_p;
        state_d = ST_FADD;
      end
      ST_FADD: begin
        if (crossed && cnt_q < NEEDED) begin
          if (cnt_q == SIXTH_IDX) sixth_d = pos_q - 1'b1;
          if (cnt_q == LAST_IDX) last_d = pos_q - 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        flt_d = nxt;
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          state_d = ST_CHECK;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (cnt_q == NEEDED && last_q > sixth_q) begin
          state_d = ST_RMUL;
        end else begin
          res_f_d = '0;
          res_v_d = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_RMUL: begin
        mul_a   = MUL_A_W'(rate_q);
        mul_b   = RATE_SCALE;
        prod_d  = mul_p;
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_f_d = freq;
          res_v_d = 1'b1;
          if (freq <= low_q && (la || sa)) begin
            if (la) relay_d[0] = 1'b0;
            if (sa) relay_d[1] = 1'b0;
          end else if (freq >= high_q && (la || sa)) begin
            if (la) relay_d[0] = 1'b1;
            if (sa) relay_d[1] = 1'b1;
          end else if (lm || sm) begin
            if (lm) relay_d[0] = 1'b1;
            if (sm) relay_d[1] = 1'b1;
          end else if (!(la && sa)) begin
            relay_d = 2'b00;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {6'b0, relay_q, res_f_q};
          muser_d  = res_v_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      flt_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      sixth_q  <= '0;
      last_q   <= '0;
      relay_q  <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      flt_q    <= flt_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      sixth_q  <= sixth_d;
      last_q   <= last_d;
      relay_q  <= relay_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prod_q  <= prod_d;
    part_q  <= part_d;
    res_f_q <= res_f_d;
    res_v_q <= res_v_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

`default_nettype wire

/* tb/sv/mains_frequency_relay_controller_test.sv */
// Self-checking testbench of mains_frequency_relay_controller: whole sample frames in,
// one frequency/relay result per frame out, checked against an in-bench frame predictor.
// Depends on mfrc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module mains_frequency_relay_controller_test;
  import mfrc_pkg::*;

  localparam int unsigned DIRECTED_ROWS  = 10;
  localparam int unsigned RANDOM_PHASES  = 14;
  localparam int unsigned PRESSURE_PHASE = 3;
  localparam int unsigned HOLD_CYCLES    = 50000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned MAX_FRAMES     = DIRECTED_ROWS + 3 * RANDOM_PHASES;
  localparam int unsigned CYCLE_LIMIT    =
    4 * (MAX_FRAMES * (FRAME_LEN * 10 + 100 + SETTLE_CYCLES) + HOLD_CYCLES);

  typedef enum logic [2:0] {
    WAVE_FLAT,
    WAVE_SQUARE,
    WAVE_TRIANGLE,
    WAVE_SAW,
    WAVE_NOISE
  } wave_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] level;
    logic [RATE_W-1:0]   rate;
    logic [FREQ_W-1:0]   low_limit;
    logic [FREQ_W-1:0]   high_limit;
    logic [3:0]          modes;
  } relay_cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              valid;
    logic              light;
    logic              socket;
  } freq_result_t;

  typedef struct packed {
    relay_cfg_t          cfg;
    wave_e               wave;
    logic [15:0]         period;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] jitter;
    logic                typed;
    freq_result_t        want;
  } mains_frame_t;

  localparam relay_cfg_t DEFAULT_CFG =
    '{16'd1996, 10'd511, 16'd10000, 24'd49975, 24'd50025, 4'd0};
  localparam freq_result_t NO_TYPED = '0;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mains_frequency_relay_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // predictor state
  relay_cfg_t          cfg_mirror  = DEFAULT_CFG;
  logic [LEVEL_W-1:0]  level_acc   = '0;
  logic [POS_W-1:0]    frame_pos   = '0;
  logic [CNT_W-1:0]    crossings   = '0;
  logic [POS_W-1:0]    sixth_at    = '0;
  logic [POS_W-1:0]    last_at     = '0;
  logic [1:0]          relay_state = '0;

  freq_result_t  pending_results[$];
  mains_frame_t  directed_frames[DIRECTED_ROWS];

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned valid_count     = 0;
  int unsigned saturated_count = 0;
  int unsigned samples_sent    = 0;
  int unsigned cycle_count     = 0;

  // One sample through the frame predictor; returns 1 with the frame result at frame end.
  function automatic logic step_frame_model(input logic [SAMPLE_W-1:0] x,
                                            output freq_result_t res);
    logic [63:0]        acc;
    logic [63:0]        quotient;
    logic [LEVEL_W-1:0] next_level;
    logic [LEVEL_W-1:0] threshold;
    logic [POS_W-1:0]   p;
    logic [1:0]         d;
    logic               la, sa, lm, sm;
    p   = frame_pos;
    res = '0;
    if (p == '0) begin
      level_acc = '0;
      crossings = '0;
      sixth_at  = '0;
      last_at   = '0;
    end else begin
      acc = 64'(level_acc) * (64'd65536 - 64'(cfg_mirror.gain))
          + ((64'(x) << 16) * 64'(cfg_mirror.gain)) + 64'd32768;
      next_level = acc[16 +: LEVEL_W];
      threshold  = {cfg_mirror.level, 16'd0};
      if (((level_acc < threshold) != (next_level < threshold)) && crossings < NEEDED) begin
        if (crossings == SIXTH_IDX) sixth_at = p - 1'b1;
        if (crossings == LAST_IDX) last_at = p - 1'b1;
        crossings = crossings + 1'b1;
      end
      level_acc = next_level;
    end
    if (32'(p) + 1 < FRAME_LEN) begin
      frame_pos = p + 1'b1;
      return 1'b0;
    end
    frame_pos = '0;
    if (crossings >= NEEDED && last_at > sixth_at) begin
      quotient  = (64'(cfg_mirror.rate) * 64'(RATE_SCALE)) / 64'(last_at - sixth_at);
      res.freq  = (quotient > 64'(FREQ_MAX)) ? FREQ_MAX : quotient[FREQ_W-1:0];
      res.valid = 1'b1;
      {sm, lm, sa, la} = cfg_mirror.modes;
      d = relay_state;
      // auto-off is tested first, so it wins when both limits match
      if (res.freq <= cfg_mirror.low_limit && (la || sa)) begin
        if (la) d[0] = 1'b0;
        if (sa) d[1] = 1'b0;
      end else if (res.freq >= cfg_mirror.high_limit && (la || sa)) begin
        if (la) d[0] = 1'b1;
        if (sa) d[1] = 1'b1;
      end else if (lm || sm) begin
        if (lm) d[0] = 1'b1;
        if (sm) d[1] = 1'b1;
      end else if (!(la && sa)) begin
        d = 2'b00;
      end
      relay_state = d;
    end
    res.light  = relay_state[0];
    res.socket = relay_state[1];
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] wave_sample(input mains_frame_t fr, input int idx);
    int ph, half, span, per, v;
    per  = int'(fr.period);
    ph   = idx % per;
    half = per / 2;
    span = int'(fr.hi) - int'(fr.lo);
    case (fr.wave)
      WAVE_SQUARE:   v = (ph < half) ? int'(fr.hi) : int'(fr.lo);
      WAVE_TRIANGLE: v = (ph < half) ? int'(fr.lo) + span * ph / half
                                     : int'(fr.hi) - span * (ph - half) / (per - half);
      WAVE_SAW:      v = int'(fr.lo) + span * ph / per;
      WAVE_NOISE:    v = int'($urandom_range(int'(fr.hi), int'(fr.lo)));
      default:       v = int'(fr.hi);
    endcase
    if (fr.jitter != '0) begin
      v = v + int'($urandom_range(0, 2 * int'(fr.jitter))) - int'(fr.jitter);
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic program_regs(input relay_cfg_t c);
    write_reg(CFG_FILTER_GAIN, CFG_DATA_W'(c.gain));
    write_reg(CFG_CROSS_LEVEL, CFG_DATA_W'(c.level));
    write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(c.rate));
    write_reg(CFG_LOW_LIMIT, c.low_limit);
    write_reg(CFG_HIGH_LIMIT, c.high_limit);
    write_reg(CFG_RELAY_MODES, CFG_DATA_W'(c.modes));
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_mirror  = c;
  endtask

  task automatic put_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_frame(input mains_frame_t fr);
    logic [SAMPLE_W-1:0] x;
    freq_result_t        res;
    for (int i = 0; i < int'(FRAME_LEN); i++) begin
      x = wave_sample(fr, i);
      put_sample(x);
      samples_sent++;
      if (step_frame_model(x, res)) pending_results.push_back(fr.typed ? fr.want : res);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(0, 2);
        repeat (gap) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    freq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no frame result pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.valid) valid_count++;
        if (want.freq == FREQ_MAX) saturated_count++;
        if (m_axis_tdata[FREQ_W-1:0] !== want.freq) begin
          $error("frequency_mhz: expected %0d, got %0d", want.freq, m_axis_tdata[FREQ_W-1:0]);
          error_count++;
        end
        if (m_axis_tuser !== want.valid) begin
          $error("frequency_valid: expected %0d, got %0d", want.valid, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[24] !== want.light) begin
          $error("light_relay: expected %0d, got %0d", want.light, m_axis_tdata[24]);
          error_count++;
        end
        if (m_axis_tdata[25] !== want.socket) begin
          $error("socket_relay: expected %0d, got %0d", want.socket, m_axis_tdata[25]);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    relay_cfg_t   rc;
    mains_frame_t fr;
    longint       f_est;
    int           frames_in_phase;
    int           period;
    int           wlo, whi;

    // flat input: one crossing on the rise, so invalid and relays stay off
    directed_frames[0] = '{DEFAULT_CFG, WAVE_FLAT, 16'd2, 10'd1023, 10'd1023, 10'd0,
                           1'b1, '{24'd0, 1'b0, 1'b0, 1'b0}};
    directed_frames[1] = '{DEFAULT_CFG, WAVE_SQUARE, 16'd200, 10'd0, 10'd1023, 10'd0,
                           1'b0, NO_TYPED};
    directed_frames[2] = '{'{16'd1996, 10'd511, 16'd10000, 24'd0, 24'd40000, 4'b0011},
                           WAVE_SQUARE, 16'd200, 10'd0, 10'd1023, 10'd0, 1'b0, NO_TYPED};
    // crossing every sample: quotient saturates, manual drives both on
    directed_frames[3] = '{'{16'd65535, 10'd511, 16'd65535, 24'd0, FREQ_MAX, 4'b1100},
                           WAVE_SQUARE, 16'd2, 10'd0, 10'd1023, 10'd0,
                           1'b1, '{FREQ_MAX, 1'b1, 1'b1, 1'b1}};
    // both limits match: auto-off wins
    directed_frames[4] = '{'{16'd65535, 10'd511, 16'd65535, FREQ_MAX, FREQ_MAX, 4'b0011},
                           WAVE_SQUARE, 16'd2, 10'd0, 10'd1023, 10'd0,
                           1'b1, '{FREQ_MAX, 1'b1, 1'b0, 1'b0}};
    // zero sample rate: frequency 0 but valid
    directed_frames[5] = '{'{16'd65535, 10'd511, 16'd0, 24'd100, 24'd200, 4'b1000},
                           WAVE_SQUARE, 16'd2, 10'd0, 10'd1023, 10'd0,
                           1'b1, '{24'd0, 1'b1, 1'b0, 1'b1}};
    // zero gain keeps the level at zero: no crossings, relays hold
    directed_frames[6] = '{'{16'd0, 10'd511, 16'd10000, 24'd0, 24'd0, 4'b0000},
                           WAVE_NOISE, 16'd2, 10'd0, 10'd1023, 10'd0,
                           1'b1, '{24'd0, 1'b0, 1'b0, 1'b1}};
    // level 0: nothing is ever below it
    directed_frames[7] = '{'{16'd65535, 10'd0, 16'd10000, 24'd0, FREQ_MAX, 4'b0101},
                           WAVE_NOISE, 16'd2, 10'd0, 10'd1023, 10'd0,
                           1'b1, '{24'd0, 1'b0, 1'b0, 1'b1}};
    directed_frames[8] = '{'{16'd65535, 10'd1023, 16'd10000, 24'd0, FREQ_MAX, 4'b0010},
                           WAVE_SQUARE, 16'd2, 10'd0, 10'd1023, 10'd0, 1'b0, NO_TYPED};
    directed_frames[9] = '{'{16'd1996, 10'd480, 16'd20000, 24'd1000, 24'd2000000, 4'b0001},
                           WAVE_TRIANGLE, 16'd120, 10'd100, 10'd900, 10'd30, 1'b0, NO_TYPED};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < int'(DIRECTED_ROWS); r++) begin
      drain_results();
      program_regs(directed_frames[r].cfg);
      send_frame(directed_frames[r]);
    end

    for (int ph = 0; ph < int'(RANDOM_PHASES); ph++) begin
      idle_on = (ph < int'(RANDOM_PHASES) - 3);
      period  = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 19) : $urandom_range(20, 230);
      wlo     = $urandom_range(0, 400);
      whi     = $urandom_range(600, 1023);
      case ($urandom_range(0, 5))
        0:       rc.gain = 16'd1996;
        1:       rc.gain = 16'hFFFF;
        2:       rc.gain = GAIN_W'($urandom_range(0, 65535));
        default: rc.gain = GAIN_W'($urandom_range(3000, 40000));
      endcase
      case ($urandom_range(0, 5))
        0:       rc.rate = 16'd10000;
        1:       rc.rate = 16'hFFFF;
        2:       rc.rate = 16'd1;
        3:       rc.rate = RATE_W'($urandom_range(5000, 20000));
        default: rc.rate = RATE_W'($urandom_range(1, 65535));
      endcase
      rc.level = SAMPLE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                           : (wlo + whi) / 2 + $urandom_range(0, 40) - 20);
      f_est = longint'(rc.rate) * 1000 / period;
      case ($urandom_range(0, 3))
        0: begin
          rc.low_limit  = 24'd49975;
          rc.high_limit = 24'd50025;
        end
        1: begin
          rc.low_limit  = FREQ_W'(f_est * $urandom_range(50, 150) / 100);
          rc.high_limit = FREQ_W'(f_est * $urandom_range(50, 150) / 100);
        end
        2: begin
          rc.low_limit  = FREQ_W'($urandom_range(0, 16777215));
          rc.high_limit = FREQ_W'($urandom_range(0, 16777215));
        end
        default: begin
          rc.low_limit  = $urandom_range(0, 1) ? FREQ_MAX : '0;
          rc.high_limit = $urandom_range(0, 1) ? FREQ_MAX : '0;
        end
      endcase
      rc.modes = 4'($urandom_range(0, 15));

      drain_results();
      program_regs(rc);
      frames_in_phase = (ph == int'(PRESSURE_PHASE)) ? 3 : $urandom_range(1, 3);
      if (ph == int'(PRESSURE_PHASE)) hold_req = 1'b1;
      repeat (frames_in_phase) begin
        fr.cfg    = rc;
        fr.period = 16'(period);
        fr.lo     = SAMPLE_W'(wlo);
        fr.hi     = SAMPLE_W'(whi);
        fr.jitter = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(1, 60)) : '0;
        fr.typed  = 1'b0;
        fr.want   = NO_TYPED;
        case ($urandom_range(0, 9))
          0: begin
            fr.wave = WAVE_NOISE;
            fr.lo   = '0;
            fr.hi   = 10'd1023;
          end
          1:          fr.wave = WAVE_FLAT;
          2, 3, 4:    fr.wave = WAVE_SQUARE;
          5, 6, 7:    fr.wave = WAVE_TRIANGLE;
          default:    fr.wave = WAVE_SAW;
        endcase
        send_frame(fr);
      end
    end

    drain_results();
    $display("Checked %0d frame results from %0d samples: %0d valid, %0d saturated frequencies.",
             results_checked, samples_sent, valid_count, saturated_count);
    $display("Register extremes, all relay modes and a long output hold-off were exercised.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mfrc_pkg.sv
src/mfrc_div.sv
src/mains_frequency_relay_controller.sv
tb/sv/mains_frequency_relay_controller_test.sv
